>>> rtl/gdw_pkg.sv
// Shared types and constants for the grid depth-first step walker.
// No dependencies; every other file imports this package.
package gdw_pkg;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 5;
  localparam int KIND_W  = 2;
  localparam int DIR_W   = 3;
  localparam int DEPTH_W = 12;
  localparam int NB_CNT  = 4;
  localparam int NBW     = $clog2(NB_CNT);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

  // Cell kinds
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 2'd2;

  // Neighbor slots; a move direction code equals its slot number
  localparam int NB_UP    = 0;
  localparam int NB_DOWN  = 1;
  localparam int NB_LEFT  = 2;
  localparam int NB_RIGHT = 3;

  localparam logic [DIR_W-1:0] DIR_STAY = 3'd4;

  localparam logic [DEPTH_W-1:0] DEPTH_START = 12'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_DEAD  = 12'hFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 12'h7FF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_MARK,
    S_FETCH,
    S_SETTLE,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                map_we;
    logic                depth_we;
    logic [KIND_W-1:0]   map_wdata;
    logic [DEPTH_W-1:0]  depth_wdata;
  } mem_ctl_t;

  typedef struct packed {
    logic               advance;
    logic               retreat;
    logic [DIR_W-1:0]   dir;
    logic [DEPTH_W-1:0] new_depth;
  } step_dec_t;

  typedef struct packed {
    logic [DIR_W-1:0]   move_dir;
    logic [COORD_W-1:0] now_row;
    logic [COORD_W-1:0] now_col;
  } res_t;

endpackage

>>> rtl/gdw_ifs.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on gdw_pkg for field widths.
interface gdw_in_if;
  import gdw_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [KIND_W-1:0]  cell_kind;
  logic [COORD_W-1:0] target_row;
  logic [COORD_W-1:0] target_col;
  logic               target_valid;
  logic [COORD_W-1:0] avoid_row;
  logic [COORD_W-1:0] avoid_col;

  modport source (output valid, cmd, row, col, cell_kind, target_row, target_col,
                  target_valid, avoid_row, avoid_col, input ready);
  modport sink (input valid, cmd, row, col, cell_kind, target_row, target_col,
                target_valid, avoid_row, avoid_col, output ready);
endinterface

interface gdw_out_if;
  import gdw_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIR_W-1:0]   move_dir;
  logic [COORD_W-1:0] now_row;
  logic [COORD_W-1:0] now_col;

  modport source (output valid, move_dir, now_row, now_col, input ready);
  modport sink (input valid, move_dir, now_row, now_col, output ready);
endinterface

>>> rtl/gdw_store.sv
// Cell map and depth store: two synchronous RAMs sharing one read address,
// one write address, read data registered. Depends on gdw_pkg.
module gdw_store #(
  parameter int AW = 10
) (
  input  logic                     clk,
  input  gdw_pkg::mem_ctl_t        mem_ctl,
  input  logic [AW-1:0]            wr_addr,
  input  logic [AW-1:0]            rd_addr,
  output logic [gdw_pkg::KIND_W-1:0]  map_rd,
  output logic [gdw_pkg::DEPTH_W-1:0] depth_rd
);
  import gdw_pkg::*;

  localparam int ENTRIES = 1 << AW;

  logic [KIND_W-1:0]  map_mem   [ENTRIES];
  logic [DEPTH_W-1:0] depth_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (mem_ctl.map_we) begin
      map_mem[wr_addr] <= mem_ctl.map_wdata;
    end
    if (mem_ctl.depth_we) begin
      depth_mem[wr_addr] <= mem_ctl.depth_wdata;
    end
    map_rd   <= map_mem[rd_addr];
    depth_rd <= depth_mem[rd_addr];
  end

endmodule

>>> rtl/gdw_nbr.sv
// Neighbor unit: neighbor coordinates, grid bounds and the advance/retreat
// choice for one step. Depends on gdw_pkg.
module gdw_nbr #(
  parameter int GRID_SIDE = 32,
  localparam int XW = $clog2(GRID_SIDE)
) (
  input  logic [XW-1:0]                                   walker_row,
  input  logic [XW-1:0]                                   walker_col,
  input  logic [gdw_pkg::COORD_W-1:0]                     avoid_row,
  input  logic [gdw_pkg::COORD_W-1:0]                     avoid_col,
  input  logic [gdw_pkg::DEPTH_W-1:0]                     here_depth,
  input  logic [gdw_pkg::NB_CNT-1:0][gdw_pkg::DEPTH_W-1:0] nb_depth,
  input  logic [gdw_pkg::NB_CNT-1:0][gdw_pkg::KIND_W-1:0]  nb_kind,
  output logic [gdw_pkg::NB_CNT-1:0][XW-1:0]              nb_row,
  output logic [gdw_pkg::NB_CNT-1:0][XW-1:0]              nb_col,
  output gdw_pkg::step_dec_t                              dec
);
  import gdw_pkg::*;

  localparam int CMPW = (XW > COORD_W) ? XW : COORD_W;
  localparam logic [XW-1:0] EDGE = XW'(GRID_SIDE - 1);

  logic [NB_CNT-1:0]  nb_in;
  logic [NB_CNT-1:0]  adv_ok;
  logic [NB_CNT-1:0]  ret_ok;
  logic [DEPTH_W-1:0] back_depth;

  always_comb begin
    nb_row[NB_UP]    = walker_row - XW'(1);
    nb_col[NB_UP]    = walker_col;
    nb_in[NB_UP]     = (walker_row != '0);
    nb_row[NB_DOWN]  = walker_row + XW'(1);
    nb_col[NB_DOWN]  = walker_col;
    nb_in[NB_DOWN]   = (walker_row != EDGE);
    nb_row[NB_LEFT]  = walker_row;
    nb_col[NB_LEFT]  = walker_col - XW'(1);
    nb_in[NB_LEFT]   = (walker_col != '0);
    nb_row[NB_RIGHT] = walker_row;
    nb_col[NB_RIGHT] = walker_col + XW'(1);
    nb_in[NB_RIGHT]  = (walker_col != EDGE);
  end

  assign back_depth = here_depth - DEPTH_W'(1);

  always_comb begin
    for (int d = 0; d < NB_CNT; d++) begin
      adv_ok[d] = nb_in[d] && (nb_kind[d] == KIND_OPEN) && (nb_depth[d] == '0) &&
                  !((CMPW'(avoid_row) == CMPW'(nb_row[d])) &&
                    (CMPW'(avoid_col) == CMPW'(nb_col[d])));
      ret_ok[d] = nb_in[d] && (nb_depth[d] == back_depth);
    end
  end

  // First match wins: scan from the last slot down so the lowest one sticks.
  always_comb begin
    dec.advance   = 1'b0;
    dec.retreat   = 1'b0;
    dec.dir       = DIR_STAY;
    dec.new_depth = (here_depth == DEPTH_MAX) ? DEPTH_MAX : here_depth + DEPTH_W'(1);
    if (|adv_ok) begin
      dec.advance = 1'b1;
      for (int d = NB_CNT - 1; d >= 0; d--) begin
        if (adv_ok[d]) begin
          dec.dir = DIR_W'(d);
        end
      end
    end else if (|ret_ok) begin
      dec.retreat = 1'b1;
      for (int d = NB_CNT - 1; d >= 0; d--) begin
        if (ret_ok[d]) begin
          dec.dir = DIR_W'(d);
        end
      end
    end
  end

endmodule

>>> rtl/gdw_seq.sv
// Command sequencer: clear sweeps, neighbor fetch over the store's read port,
// decision and write-back. Depends on gdw_pkg, gdw_ifs and gdw_nbr.
module gdw_seq #(
  parameter int GRID_SIDE = 32,
  localparam int XW = $clog2(GRID_SIDE),
  localparam int AW = 2 * XW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gdw_in_if.sink                      in_ch,
  output logic                        res_valid,
  input  logic                        res_ready,
  output gdw_pkg::res_t               res,
  output gdw_pkg::mem_ctl_t           mem_ctl,
  output logic [AW-1:0]               wr_addr,
  output logic [AW-1:0]               rd_addr,
  input  logic [gdw_pkg::KIND_W-1:0]  map_rd,
  input  logic [gdw_pkg::DEPTH_W-1:0] depth_rd
);
  import gdw_pkg::*;

  localparam int CMPW = (XW > COORD_W) ? XW : COORD_W;
  localparam int KW   = $clog2(NB_CNT + 2);
  localparam logic [KW-1:0] LAST_SLOT = KW'(NB_CNT);
  localparam logic [AW-1:0] CLR_LAST  = '1;

  state_t state_r, state_nxt;

  logic [KW-1:0]  k_r;
  logic [AW-1:0]  clr_addr_r;
  logic           clr_map_r;
  logic [XW-1:0]  walker_row_r;
  logic [XW-1:0]  walker_col_r;
  logic [DIR_W-1:0] dir_r;

  logic [CMD_W-1:0]   cmd_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [KIND_W-1:0]  kind_r;
  logic [COORD_W-1:0] tgt_row_r;
  logic [COORD_W-1:0] tgt_col_r;
  logic               tgt_valid_r;
  logic [COORD_W-1:0] avoid_row_r;
  logic [COORD_W-1:0] avoid_col_r;

  logic [DEPTH_W-1:0]                 here_depth_r;
  logic [NB_CNT-1:0][DEPTH_W-1:0]     nb_depth_r;
  logic [NB_CNT-1:0][KIND_W-1:0]      nb_kind_r;

  logic [NB_CNT-1:0][XW-1:0] nb_row;
  logic [NB_CNT-1:0][XW-1:0] nb_col;
  step_dec_t                 dec;

  logic           in_acc;
  logic           start_in_grid;
  logic           tgt_hit;
  logic           clr_done;
  logic [AW-1:0]  here_addr;
  logic [AW-1:0]  cell_addr;
  logic [AW-1:0]  move_addr;
  logic [NBW-1:0] rd_nb;
  logic [NBW-1:0] cap_nb;
  logic           cap_en;

  gdw_nbr #(.GRID_SIDE(GRID_SIDE)) u_nbr (
    .walker_row (walker_row_r),
    .walker_col (walker_col_r),
    .avoid_row  (avoid_row_r),
    .avoid_col  (avoid_col_r),
    .here_depth (here_depth_r),
    .nb_depth   (nb_depth_r),
    .nb_kind    (nb_kind_r),
    .nb_row     (nb_row),
    .nb_col     (nb_col),
    .dec        (dec)
  );

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign start_in_grid = (int'(row_r) < GRID_SIDE) && (int'(col_r) < GRID_SIDE);
  assign tgt_hit       = tgt_valid_r &&
                         (CMPW'(tgt_row_r) == CMPW'(walker_row_r)) &&
                         (CMPW'(tgt_col_r) == CMPW'(walker_col_r));
  assign clr_done      = (clr_addr_r == CLR_LAST);
  assign here_addr     = {walker_row_r, walker_col_r};
  assign cell_addr     = {XW'(row_r), XW'(col_r)};
  assign rd_nb         = NBW'(k_r - KW'(1));
  assign cap_nb        = NBW'(k_r - KW'(2));
  assign move_addr     = {nb_row[dec.dir[NBW-1:0]], nb_col[dec.dir[NBW-1:0]]};
  // Read data for slot k_r-1 arrives while k_r is shown; slot 0 is the walker cell.
  assign cap_en        = ((state_r == S_FETCH) && (k_r != '0)) || (state_r == S_SETTLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (cmd_r == CMD_RESTART) state_nxt = S_CLEAR;
        else if ((cmd_r == CMD_STEP) && !tgt_hit) state_nxt = S_FETCH;
        else state_nxt = S_DONE;
      end
      S_CLEAR: begin
        if (clr_done) state_nxt = clr_map_r ? S_IDLE : S_MARK;
      end
      S_MARK:   state_nxt = S_DONE;
      S_FETCH: begin
        if (k_r == LAST_SLOT) state_nxt = S_SETTLE;
      end
      S_SETTLE: state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready         = (state_r == S_IDLE);
    res_valid           = (state_r == S_DONE);
    mem_ctl.map_we      = 1'b0;
    mem_ctl.depth_we    = 1'b0;
    mem_ctl.map_wdata   = (kind_r > KIND_OPEN) ? KIND_UNKNOWN : kind_r;
    mem_ctl.depth_wdata = '0;
    wr_addr             = cell_addr;
    rd_addr             = (k_r == '0) ? here_addr : {nb_row[rd_nb], nb_col[rd_nb]};
    unique case (state_r)
      S_DISPATCH: begin
        mem_ctl.map_we = (cmd_r == CMD_WRITE) && start_in_grid;
      end
      S_CLEAR: begin
        mem_ctl.depth_we  = 1'b1;
        mem_ctl.map_we    = clr_map_r;
        mem_ctl.map_wdata = KIND_UNKNOWN;
        wr_addr           = clr_addr_r;
      end
      S_MARK: begin
        mem_ctl.depth_we    = 1'b1;
        mem_ctl.depth_wdata = DEPTH_START;
        wr_addr             = here_addr;
      end
      S_DECIDE: begin
        mem_ctl.depth_we = dec.advance || dec.retreat;
        if (dec.advance) begin
          mem_ctl.depth_wdata = dec.new_depth;
          wr_addr             = move_addr;
        end else begin
          // retreat marks the cell being left as a dead end
          mem_ctl.depth_wdata = DEPTH_DEAD;
          wr_addr             = here_addr;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_map_r    <= 1'b1;
      clr_addr_r   <= '0;
      k_r          <= '0;
      walker_row_r <= '0;
      walker_col_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_done) clr_map_r <= 1'b0;
      end
      k_r <= (state_r == S_FETCH) ? k_r + KW'(1) : '0;
      if ((state_r == S_DISPATCH) && (cmd_r == CMD_RESTART) && start_in_grid) begin
        walker_row_r <= XW'(row_r);
        walker_col_r <= XW'(col_r);
      end else if ((state_r == S_DECIDE) && (dec.advance || dec.retreat)) begin
        walker_row_r <= nb_row[dec.dir[NBW-1:0]];
        walker_col_r <= nb_col[dec.dir[NBW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r       <= in_ch.cmd;
      row_r       <= in_ch.row;
      col_r       <= in_ch.col;
      kind_r      <= in_ch.cell_kind;
      tgt_row_r   <= in_ch.target_row;
      tgt_col_r   <= in_ch.target_col;
      tgt_valid_r <= in_ch.target_valid;
      avoid_row_r <= in_ch.avoid_row;
      avoid_col_r <= in_ch.avoid_col;
    end
    if (state_r == S_DISPATCH) begin
      dir_r <= DIR_STAY;
    end else if (state_r == S_DECIDE) begin
      dir_r <= dec.dir;
    end
    if (cap_en) begin
      if (k_r == KW'(1)) begin
        here_depth_r <= depth_rd;
      end else begin
        nb_depth_r[cap_nb] <= depth_rd;
        nb_kind_r[cap_nb]  <= map_rd;
      end
    end
  end

  assign res.move_dir = dir_r;
  assign res.now_row  = COORD_W'(walker_row_r);
  assign res.now_col  = COORD_W'(walker_col_r);

endmodule

>>> rtl/grid_dfs_step_walker.sv
// Top level of the grid depth-first step walker: store, sequencer, result register.
// Depends on gdw_pkg, gdw_ifs, gdw_store and gdw_seq.
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------------
//   in_ch    | in  | cmd, row, col, cell_kind, target/avoid cell, target_valid
//   out_ch   | out | move_dir, now_row, now_col (one beat per command beat)
//
// One command at a time; the store has one read and one write port.
// Write and unused commands go from dispatch straight to the result. Step: five serial
// reads of the walker cell and its four neighbors, then decide and write back;
// the reads are skipped when the walker already sits on the target.
// Restart: the depth clear sweep over every store address, then the start cell mark.
// After reset a sweep over every store address clears both stores;
// in_ch.ready stays low until it is done.
// A result waits in the output register while the next command beat is taken.
module grid_dfs_step_walker #(
  parameter int GRID_SIDE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gdw_in_if.sink     in_ch,
  gdw_out_if.source  out_ch
);
  import gdw_pkg::*;

  localparam int AW = 2 * $clog2(GRID_SIDE);

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [KIND_W-1:0]  map_rd;
  logic [DEPTH_W-1:0] depth_rd;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               out_valid_r;
  res_t               out_res_r;

  gdw_store #(.AW(AW)) u_store (
    .clk      (clk),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .map_rd   (map_rd),
    .depth_rd (depth_rd)
  );

  gdw_seq #(.GRID_SIDE(GRID_SIDE)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .map_rd    (map_rd),
    .depth_rd  (depth_rd)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.move_dir = out_res_r.move_dir;
  assign out_ch.now_row  = out_res_r.now_row;
  assign out_ch.now_col  = out_res_r.now_col;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command beat taken while sequencer busy");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("result lost on the way to the output register");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.move_dir <= DIR_STAY))
    else $error("move_dir out of range");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ch.ready)
    else $error("command beat taken before the clear sweep");
`endif

endmodule

>>> tb/tb.sv
// Self-checking bench for grid_dfs_step_walker: command beats in, one move beat out.
// Depends on gdw_pkg and the gdw_in_if/gdw_out_if channel interfaces.
// A directed table comes first, then random map/restart/walk episodes; each result is checked
// against the table's expected beat where it gives one, else against a walker model in this file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gdw_pkg::*;

  localparam int GRID_SIDE = 32;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ITEM_GOAL = 850;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [KIND_W-1:0]  cell_kind;
    logic [COORD_W-1:0] target_row;
    logic [COORD_W-1:0] target_col;
    logic               target_valid;
    logic [COORD_W-1:0] avoid_row;
    logic [COORD_W-1:0] avoid_col;
  } walk_cmd_t;

  typedef struct {
    walk_cmd_t beat;
    bit        typed;
    res_t      want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  gdw_in_if cmd_if ();
  gdw_out_if res_if ();

  grid_dfs_step_walker #(.GRID_SIDE(GRID_SIDE)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (res_if)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walker model state
  logic [KIND_W-1:0]  map_kind [CELLS];
  logic [DEPTH_W-1:0] depth_mark [CELLS];
  logic [COORD_W-1:0] walk_r;
  logic [COORD_W-1:0] walk_c;

  res_t expected_moves [$];
  int   mismatches = 0;
  int   beats_sent = 0;
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;

  function automatic int cell_at(int r, int c);
    return r * GRID_SIDE + c;
  endfunction

  function automatic logic [DIR_W-1:0] predict_step(walk_cmd_t b);
    int wr, wc, nr, nc, here;
    logic [DEPTH_W-1:0] cur;
    wr = int'(walk_r);
    wc = int'(walk_c);
    here = cell_at(wr, wc);
    cur = depth_mark[here];
    if (b.target_valid && b.target_row == walk_r && b.target_col == walk_c) return DIR_STAY;
    // advance into the first fresh open neighbor
    for (int d = 0; d < NB_CNT; d++) begin
      nr = wr;
      nc = wc;
      case (d)
        NB_UP:    nr = wr - 1;
        NB_DOWN:  nr = wr + 1;
        NB_LEFT:  nc = wc - 1;
        default:  nc = wc + 1;
      endcase
      if (nr < 0 || nr >= GRID_SIDE || nc < 0 || nc >= GRID_SIDE) continue;
      if (map_kind[cell_at(nr, nc)] == KIND_OPEN && depth_mark[cell_at(nr, nc)] == '0 &&
          !(nr == int'(b.avoid_row) && nc == int'(b.avoid_col))) begin
        depth_mark[cell_at(nr, nc)] = (cur == DEPTH_MAX) ? DEPTH_MAX : cur + 12'd1;
        walk_r = nr[COORD_W-1:0];
        walk_c = nc[COORD_W-1:0];
        return d[DIR_W-1:0];
      end
    end
    // back off along the path, leaving a dead mark behind
    for (int d = 0; d < NB_CNT; d++) begin
      nr = wr;
      nc = wc;
      case (d)
        NB_UP:    nr = wr - 1;
        NB_DOWN:  nr = wr + 1;
        NB_LEFT:  nc = wc - 1;
        default:  nc = wc + 1;
      endcase
      if (nr < 0 || nr >= GRID_SIDE || nc < 0 || nc >= GRID_SIDE) continue;
      if (depth_mark[cell_at(nr, nc)] == cur - 12'd1) begin
        depth_mark[here] = DEPTH_DEAD;
        walk_r = nr[COORD_W-1:0];
        walk_c = nc[COORD_W-1:0];
        return d[DIR_W-1:0];
      end
    end
    return DIR_STAY;
  endfunction

  function automatic res_t predict_walk(walk_cmd_t b);
    res_t r;
    r.move_dir = DIR_STAY;
    case (b.cmd)
      CMD_WRITE: begin
        map_kind[cell_at(int'(b.row), int'(b.col))] =
          (b.cell_kind == KIND_BAD) ? KIND_UNKNOWN : b.cell_kind;
      end
      CMD_RESTART: begin
        foreach (depth_mark[i]) depth_mark[i] = '0;
        walk_r = b.row;
        walk_c = b.col;
        depth_mark[cell_at(int'(b.row), int'(b.col))] = DEPTH_START;
      end
      CMD_STEP: r.move_dir = predict_step(b);
      default: ;
    endcase
    r.now_row = walk_r;
    r.now_col = walk_c;
    return r;
  endfunction

  function automatic walk_cmd_t mk_cmd(logic [CMD_W-1:0] c, logic [COORD_W-1:0] r,
                                       logic [COORD_W-1:0] col, logic [KIND_W-1:0] k,
                                       logic [COORD_W-1:0] tr, logic [COORD_W-1:0] tc,
                                       logic tv, logic [COORD_W-1:0] ar,
                                       logic [COORD_W-1:0] ac);
    walk_cmd_t b;
    b.cmd = c;
    b.row = r;
    b.col = col;
    b.cell_kind = k;
    b.target_row = tr;
    b.target_col = tc;
    b.target_valid = tv;
    b.avoid_row = ar;
    b.avoid_col = ac;
    return b;
  endfunction

  function automatic walk_cmd_t rand_beat();
    return mk_cmd(CMD_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 31)),
                  COORD_W'($urandom_range(0, 31)), KIND_W'($urandom_range(0, 3)),
                  COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 31)),
                  COORD_W'($urandom_range(0, 31)));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_walk_cmd(walk_cmd_t b, bit typed, res_t typed_res);
    int gap;
    res_t model_res;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= b.cmd;
    cmd_if.row <= b.row;
    cmd_if.col <= b.col;
    cmd_if.cell_kind <= b.cell_kind;
    cmd_if.target_row <= b.target_row;
    cmd_if.target_col <= b.target_col;
    cmd_if.target_valid <= b.target_valid;
    cmd_if.avoid_row <= b.avoid_row;
    cmd_if.avoid_col <= b.avoid_col;
    do @(posedge clk); while (!cmd_if.ready);
    model_res = predict_walk(b);
    expected_moves.push_back(typed ? typed_res : model_res);
    if (b.cmd != CMD_UNUSED) beats_sent++;
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int stall;
    res_t got, want;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.move_dir = res_if.move_dir;
      got.now_row = res_if.now_row;
      got.now_col = res_if.now_col;
      if (expected_moves.size() == 0) begin
        report_mismatch("unexpected result move_dir", int'(got.move_dir), -1);
      end else begin
        want = expected_moves.pop_front();
        if (got.move_dir !== want.move_dir)
          report_mismatch("move_dir", int'(got.move_dir), int'(want.move_dir));
        if (got.now_row !== want.now_row)
          report_mismatch("now_row", int'(got.now_row), int'(want.now_row));
        if (got.now_col !== want.now_col)
          report_mismatch("now_col", int'(got.now_col), int'(want.now_col));
      end
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    plan_row_t plan [$];
    walk_cmd_t b;
    int span, base_r, base_c, n_wr, n_st, pick;
    logic [COORD_W-1:0] tr, tc, ar, ac;
    logic tv;

    foreach (map_kind[i]) map_kind[i] = KIND_UNKNOWN;
    foreach (depth_mark[i]) depth_mark[i] = '0;
    walk_r = '0;
    walk_c = '0;

    rst_n <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd <= CMD_WRITE;
    cmd_if.row <= '0;
    cmd_if.col <= '0;
    cmd_if.cell_kind <= KIND_UNKNOWN;
    cmd_if.target_row <= '0;
    cmd_if.target_col <= '0;
    cmd_if.target_valid <= 1'b0;
    cmd_if.avoid_row <= '0;
    cmd_if.avoid_col <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner cells, edge neighbors, advance, retreat, target hold, odd codes
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 0, 0, KIND_OPEN, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 0, 1, KIND_BAD, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 1, 0, KIND_OPEN, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 0, 2, KIND_UNKNOWN, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 31, 31, KIND_OPEN, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 31, 30, KIND_OPEN, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_WRITE, 30, 31, KIND_WALL, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_RESTART, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd0, 5'd0}});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 31, 31), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 31, 31), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 31, 31), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_RESTART, 31, 31, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd31, 5'd31}});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 31, 31, 1, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd31, 5'd31}});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 31, 31, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 31, 31, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_WRITE, 31, 31, KIND_BAD, 31, 31, 1, 31, 31), 1'b1,
                     '{DIR_STAY, 5'd31, 5'd31}});
    plan.push_back('{mk_cmd(CMD_UNUSED, 31, 31, KIND_BAD, 31, 31, 1, 31, 31), 1'b1,
                     '{DIR_STAY, 5'd31, 5'd31}});
    plan.push_back('{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_cmd(CMD_RESTART, 5, 17, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{DIR_STAY, 5'd5, 5'd17}});

    foreach (plan[i]) send_walk_cmd(plan[i].beat, plan[i].typed, plan[i].want);
    drain_results();

    // Random episodes: paint a patch of map, restart inside it, then walk
    while (beats_sent < ITEM_GOAL) begin
      send_calm = ($urandom_range(0, 3) == 0);
      span = $urandom_range(4, 8);
      base_r = $urandom_range(0, GRID_SIDE - span);
      base_c = $urandom_range(0, GRID_SIDE - span);
      n_wr = $urandom_range(6, 24);
      repeat (n_wr) begin
        b = rand_beat();
        b.cmd = CMD_WRITE;
        b.row = COORD_W'(base_r + $urandom_range(0, span - 1));
        b.col = COORD_W'(base_c + $urandom_range(0, span - 1));
        pick = $urandom_range(0, 19);
        b.cell_kind = (pick < 14) ? KIND_OPEN : (pick < 17) ? KIND_WALL :
                      (pick < 19) ? KIND_UNKNOWN : KIND_BAD;
        send_walk_cmd(b, 1'b0, '0);
      end
      if ($urandom_range(0, 3) == 0) drain_results();

      b = rand_beat();
      b.cmd = CMD_RESTART;
      b.row = COORD_W'(base_r + $urandom_range(0, span - 1));
      b.col = COORD_W'(base_c + $urandom_range(0, span - 1));
      send_walk_cmd(b, 1'b0, '0);

      tr = COORD_W'(base_r + $urandom_range(0, span - 1));
      tc = COORD_W'(base_c + $urandom_range(0, span - 1));
      tv = ($urandom_range(0, 2) == 0);
      ar = $urandom_range(0, 1) ? COORD_W'(base_r + $urandom_range(0, span - 1)) :
                                  COORD_W'($urandom_range(0, 31));
      ac = $urandom_range(0, 1) ? COORD_W'(base_c + $urandom_range(0, span - 1)) :
                                  COORD_W'($urandom_range(0, 31));
      n_st = $urandom_range(10, 40);
      repeat (n_st) begin
        b = rand_beat();
        if ($urandom_range(0, 9) == 0) begin
          // stray beat; keep restarts to the episode boundary, they cost a full sweep
          if (b.cmd == CMD_RESTART) b.cmd = CMD_UNUSED;
        end else begin
          b.cmd = CMD_STEP;
          if ($urandom_range(0, 7) != 0) begin
            b.target_row = tr;
            b.target_col = tc;
            b.target_valid = tv;
            b.avoid_row = ar;
            b.avoid_col = ac;
          end
        end
        send_walk_cmd(b, 1'b0, '0);
      end
    end
    cmd_if.valid <= 1'b0;

    for (int k = 0; k < 20000 && expected_moves.size() != 0; k++) @(posedge clk);
    if (expected_moves.size() != 0)
      report_mismatch("results never returned", expected_moves.size(), 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
